// ----- hdl/twled_pkg.sv -----
// shared types and constants for the two-wire led driver bus master
`timescale 1ns / 1ps
`default_nettype none

package twled_pkg;

    // command queue between front and engine
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    localparam int CNT_W     = 16;
    localparam int REG_IDX_W = 2;

    localparam logic [CNT_W-1:0] PHASE_TICKS_RESET = 16'd100;
    localparam logic [CNT_W-1:0] ACK_TIMEOUT_RESET = 16'd1000;

    localparam logic [REG_IDX_W-1:0] REG_PHASE_TICKS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ACK_TIMEOUT = 2'd1;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // one classified input item
    typedef struct packed {
        logic       is_load;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       dio_in;
    } item_t;

    // queue head as seen by the engine
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    // one result item
    typedef struct packed {
        logic clk_out;
        logic dio_out;
        logic dio_drive;
        logic ready_for_byte;
        logic byte_acked;
        logic ack_error;
        logic load_rejected;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/twled_front.sv -----
// input side: classifies transfers and queues them for the bus engine
`timescale 1ns / 1ps
`default_nettype none

module twled_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_opcode,
    input  wire logic [7:0]           s_data_byte,
    input  wire logic                 s_last_byte,
    input  wire logic                 s_dio_in,
    output twled_pkg::queue_head_t    head,
    input  wire logic                 pop
);

    twled_pkg::item_t queue_mem [twled_pkg::QUEUE_DEPTH];

    logic [twled_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [twled_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [twled_pkg::QUEUE_CW-1:0] count_reg, count_next;

    twled_pkg::item_t in_item;
    logic             push;
    logic             do_pop;

    always_comb begin
        in_item.is_load   = (s_opcode == twled_pkg::OP_LOAD);
        in_item.data_byte = s_data_byte;
        in_item.last_byte = s_last_byte;
        in_item.dio_in    = s_dio_in;
    end

    assign s_ready = (count_reg != twled_pkg::QUEUE_CW'(twled_pkg::QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign do_pop  = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.item  = queue_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // fill level tracks the pointer distance
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != twled_pkg::QUEUE_CW'(twled_pkg::QUEUE_DEPTH)) |->
            (count_reg[twled_pkg::QUEUE_AW-1:0] == (wr_ptr_reg - rd_ptr_reg)))
        else $error("queue count out of step with pointers");

endmodule

`default_nettype wire

// ----- hdl/twled_engine.sv -----
// bus engine: start, lsb-first byte, acknowledge wait and stop sequencing
`timescale 1ns / 1ps
`default_nettype none

module twled_engine (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [twled_pkg::REG_IDX_W-1:0]   cfg_index,
    input  wire logic [twled_pkg::CNT_W-1:0]       cfg_wdata,
    input  wire twled_pkg::queue_head_t            head,
    output logic                                   pop,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output twled_pkg::result_t                     result
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_S0, PH_S1, PH_S2, PH_S3, PH_W0,
        PH_B0, PH_B1, PH_B2, PH_A0, PH_A1, PH_AW,
        PH_AE0, PH_AE1, PH_E0, PH_E1, PH_E2, PH_E3, PH_WAIT
    } phase_t;

    logic [twled_pkg::CNT_W-1:0] phase_ticks_reg;
    logic [twled_pkg::CNT_W-1:0] ack_timeout_reg;

    phase_t                      phase_reg, phase_next;
    logic [2:0]                  bit_reg, bit_next;
    logic [7:0]                  shift_reg, shift_next;
    logic [twled_pkg::CNT_W-1:0] pcnt_reg, pcnt_next;
    logic [twled_pkg::CNT_W-1:0] acnt_reg, acnt_next;
    logic                        stop_reg, stop_next;
    logic                        err_reg, err_next;
    logic                        clk_reg, clk_next;
    logic                        dio_reg, dio_next;
    logic                        den_reg, den_next;
    logic                        m_valid_reg;
    twled_pkg::result_t          result_reg, result_next;

    logic                        acked;
    logic                        rejected;
    logic [twled_pkg::CNT_W-1:0] pcnt_inc;
    logic [twled_pkg::CNT_W-1:0] acnt_inc;
    logic [2:0]                  bit_inc;

    // one item per cycle whenever the result slot is free or being drained
    assign pop     = head.valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign result  = result_reg;

    assign pcnt_inc = pcnt_reg + 1'b1;
    assign acnt_inc = acnt_reg + 1'b1;
    assign bit_inc  = bit_reg + 1'b1;

    always_comb begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        pcnt_next  = pcnt_reg;
        acnt_next  = acnt_reg;
        stop_next  = stop_reg;
        err_next   = err_reg;
        clk_next   = clk_reg;
        dio_next   = dio_reg;
        den_next   = den_reg;
        acked      = 1'b0;
        rejected   = 1'b0;

        if (head.item.is_load) begin
            if (phase_reg == PH_IDLE || phase_reg == PH_WAIT) begin
                shift_next = head.item.data_byte;
                stop_next  = head.item.last_byte;
                bit_next   = '0;
                pcnt_next  = '0;
                if (phase_reg == PH_IDLE) begin
                    err_next   = 1'b0;
                    phase_next = PH_S0;
                end else begin
                    phase_next = PH_W0;
                end
            end else begin
                rejected = 1'b1;
            end
        end else if (phase_reg == PH_AW) begin
            // slave pulling data low wins over the timeout count
            if (!head.item.dio_in) begin
                acked      = 1'b1;
                pcnt_next  = '0;
                phase_next = PH_AE0;
            end else begin
                acnt_next = acnt_inc;
                if (acnt_inc >= ack_timeout_reg) begin
                    err_next   = 1'b1;
                    pcnt_next  = '0;
                    phase_next = PH_AE0;
                end
            end
        end else if (phase_reg != PH_IDLE && phase_reg != PH_WAIT) begin
            pcnt_next = pcnt_inc;
            if (pcnt_inc >= phase_ticks_reg) begin
                pcnt_next = '0;
                case (phase_reg)
                    PH_S0: begin
                        clk_next = 1'b0; phase_next = PH_S1;
                    end
                    PH_S1: begin
                        dio_next = 1'b1; den_next = 1'b1; phase_next = PH_S2;
                    end
                    PH_S2: begin
                        clk_next = 1'b1; phase_next = PH_S3;
                    end
                    PH_S3: begin
                        dio_next = 1'b0; phase_next = PH_W0;
                    end
                    PH_W0: begin
                        clk_next = 1'b0; bit_next = '0; phase_next = PH_B0;
                    end
                    PH_B0: begin
                        dio_next = shift_reg[0]; den_next = 1'b1; phase_next = PH_B1;
                    end
                    PH_B1: begin
                        clk_next = 1'b1; phase_next = PH_B2;
                    end
                    PH_B2: begin
                        clk_next   = 1'b0;
                        shift_next = {1'b0, shift_reg[7:1]};
                        bit_next   = bit_inc;
                        phase_next = (bit_inc == '0) ? PH_A0 : PH_B0;
                    end
                    PH_A0: begin
                        den_next = 1'b0; dio_next = 1'b1; phase_next = PH_A1;
                    end
                    PH_A1: begin
                        clk_next = 1'b1; acnt_next = '0; phase_next = PH_AW;
                    end
                    PH_AE0: begin
                        clk_next = 1'b0; phase_next = PH_AE1;
                    end
                    PH_AE1: begin
                        dio_next   = 1'b0;
                        den_next   = 1'b1;
                        phase_next = (err_reg || stop_reg) ? PH_E0 : PH_WAIT;
                    end
                    PH_E0: begin
                        clk_next = 1'b0; phase_next = PH_E1;
                    end
                    PH_E1: begin
                        dio_next = 1'b0; den_next = 1'b1; phase_next = PH_E2;
                    end
                    PH_E2: begin
                        clk_next = 1'b1; phase_next = PH_E3;
                    end
                    PH_E3: begin
                        dio_next = 1'b1; stop_next = 1'b0; phase_next = PH_IDLE;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end

        result_next.clk_out        = clk_next;
        result_next.dio_out        = dio_next;
        result_next.dio_drive      = den_next;
        result_next.ready_for_byte = (phase_next == PH_IDLE || phase_next == PH_WAIT);
        result_next.byte_acked     = acked;
        result_next.ack_error      = err_next;
        result_next.load_rejected  = rejected;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= twled_pkg::PHASE_TICKS_RESET;
            ack_timeout_reg <= twled_pkg::ACK_TIMEOUT_RESET;
            phase_reg       <= PH_IDLE;
            bit_reg         <= '0;
            shift_reg       <= '0;
            pcnt_reg        <= '0;
            acnt_reg        <= '0;
            stop_reg        <= 1'b0;
            err_reg         <= 1'b0;
            clk_reg         <= 1'b1;
            dio_reg         <= 1'b1;
            den_reg         <= 1'b1;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    twled_pkg::REG_PHASE_TICKS: phase_ticks_reg <= cfg_wdata;
                    twled_pkg::REG_ACK_TIMEOUT: ack_timeout_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (pop) begin
                phase_reg   <= phase_next;
                bit_reg     <= bit_next;
                shift_reg   <= shift_next;
                pcnt_reg    <= pcnt_next;
                acnt_reg    <= acnt_next;
                stop_reg    <= stop_next;
                err_reg     <= err_next;
                clk_reg     <= clk_next;
                dio_reg     <= dio_next;
                den_reg     <= den_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            result_reg <= result_next;
        end
    end

    // a transfer is either a load or a tick, never both outcomes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(result_reg.byte_acked && result_reg.load_rejected))
        else $error("acknowledge and reject in one result");

    // data line is released for the whole acknowledge wait
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_AW) |-> (!den_reg && clk_reg))
        else $error("data line driven during acknowledge wait");

    // idle and between-byte waits always drive the data line
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE || phase_reg == PH_WAIT) |-> den_reg)
        else $error("data line released while ready for a byte");

endmodule

`default_nettype wire

// ----- hdl/two_wire_led_driver_bus_master.sv -----
// top level of the two-wire led driver bus master
//
// usage: every s_ transfer is either one timebase tick (s_opcode 0) or a byte
// load (s_opcode 1, s_data_byte, s_last_byte). s_dio_in carries the sampled
// data line and is looked at on ticks during the acknowledge wait. every
// accepted transfer yields exactly one m_ transfer with the pin levels and
// status after that input, in order.
// path: an input transfer is written into the input queue, and its result is
// then computed from the queue head and held in the engine's result register
// until it is taken.
// throughput: one transfer per cycle while results are taken, as the engine updates on every popped item.
// configuration: cfg_wr_en with cfg_index 0 writes phase_ticks, index 1
// writes ack_timeout_ticks; other indexes are dropped. write only while idle.
// reset: engine idle, clock line high, data line driven high, error flag
// cleared, input queue empty, no result pending.
// stall: while a result waits and m_ready is low the result register holds; the
// four-entry input queue keeps taking transfers until it fills, then s_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module two_wire_led_driver_bus_master (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [twled_pkg::REG_IDX_W-1:0]  cfg_index,
    input  wire logic [twled_pkg::CNT_W-1:0]      cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_opcode,
    input  wire logic [7:0]                       s_data_byte,
    input  wire logic                             s_last_byte,
    input  wire logic                             s_dio_in,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_clk_out,
    output logic                                  m_dio_out,
    output logic                                  m_dio_drive,
    output logic                                  m_ready_for_byte,
    output logic                                  m_byte_acked,
    output logic                                  m_ack_error,
    output logic                                  m_load_rejected
);

    twled_pkg::queue_head_t head;
    twled_pkg::result_t     result;
    logic                   pop;

    twled_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .s_dio_in    (s_dio_in),
        .head        (head),
        .pop         (pop)
    );

    twled_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .head      (head),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .result    (result)
    );

    assign m_clk_out        = result.clk_out;
    assign m_dio_out        = result.dio_out;
    assign m_dio_drive      = result.dio_drive;
    assign m_ready_for_byte = result.ready_for_byte;
    assign m_byte_acked     = result.byte_acked;
    assign m_ack_error      = result.ack_error;
    assign m_load_rejected  = result.load_rejected;

endmodule

`default_nettype wire
